>>> src/bist_pkg.sv
// Shared types and constants for the bounded integer set table.
`default_nettype none
package bist_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		POS_ZERO = 2'd0,
		POS_HIT  = 2'd1,
		POS_TAIL = 2'd2
	} pos_sel_t;

	typedef struct packed {
		logic     load;
		logic     exec;
		logic     append;
		logic     delete;
		logic     success;
		logic     full;
		pos_sel_t pos_sel;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic hit;
		logic full;
	} status_t;

endpackage
`default_nettype wire

>>> src/bounded_integer_set_table_top.sv
// Top level of the bounded integer set table: controller plus datapath.
//
//  channel  | handshake      | payload
//  ---------+----------------+--------------------------------------------------
//  request  | start / busy   | operation, value
//  result   | done (strobe)  | success, position, element_count, table_full
//
// A request is taken when start is high and busy is low; busy then stays high
// for one execute cycle, in which all sixteen entries are compared in parallel
// and the append or the compacting shift is applied. The result is shown with
// done for one cycle right after, so each transaction takes two cycles and a
// new request may be taken in the cycle that carries done. The receiver cannot
// stall. Reset empties the set; entry contents need no clearing.
`default_nettype none
module bounded_integer_set_table_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 operation,
	input  wire logic [bist_pkg::VAL_W-1:0] value,
	output logic                            done,
	output logic                            success,
	output logic [bist_pkg::POS_W-1:0]      position,
	output logic [bist_pkg::CNT_W-1:0]      element_count,
	output logic                            table_full
);
	import bist_pkg::*;

	cmd_t    cmd;
	status_t status;

	bist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.status (status),
		.cmd    (cmd)
	);

	bist_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.operation     (operation),
		.value         (value),
		.success       (success),
		.position      (position),
		.element_count (element_count),
		.table_full    (table_full)
	);

endmodule
`default_nettype wire

>>> src/bist_dp.sv
// Datapath: request registers, entry table, parallel match and result registers.
`default_nettype none
module bist_dp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bist_pkg::cmd_t          cmd,
	output bist_pkg::status_t            status,
	input  wire logic [1:0]              operation,
	input  wire logic [bist_pkg::VAL_W-1:0] value,
	output logic                         success,
	output logic [bist_pkg::POS_W-1:0]   position,
	output logic [bist_pkg::CNT_W-1:0]   element_count,
	output logic                         table_full
);
	import bist_pkg::*;

	op_t              op_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] entries_q [CAPACITY];
	logic [CNT_W-1:0] count_q;
	logic [CAPACITY-1:0] match;
	logic             hit;
	logic [IDX_W-1:0] hit_idx;
	logic [CNT_W-1:0] next_count;
	logic [POS_W-1:0] pos_next;
	logic             success_q;
	logic [POS_W-1:0] position_q;
	logic [CNT_W-1:0] element_count_q;
	logic             table_full_q;

	// Every stored entry is compared against the request in parallel.
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			match[k] = (CNT_W'(k) < count_q) && (entries_q[k] == value_q);
		end
	end

	// The lowest matching index wins; the set holds no duplicates anyway.
	always_comb begin
		hit_idx = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit_idx = IDX_W'(k);
			end
		end
	end

	assign hit = |match;

	assign status.op   = op_q;
	assign status.hit  = hit;
	assign status.full = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		next_count = count_q;
		if (cmd.append) begin
			next_count = count_q + CNT_W'(1);
		end else if (cmd.delete) begin
			next_count = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		case (cmd.pos_sel)
			POS_HIT:  pos_next = POS_W'(hit_idx);
			POS_TAIL: pos_next = POS_W'(count_q[IDX_W-1:0]);
			default:  pos_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= next_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(operation);
			value_q <= value;
		end
		if (cmd.append) begin
			entries_q[count_q[IDX_W-1:0]] <= value_q;
		end
		// Removal closes the gap: every entry above the match moves down one.
		if (cmd.delete) begin
			for (int k = 0; k < CAPACITY - 1; k++) begin
				if (IDX_W'(k) >= hit_idx) begin
					entries_q[k] <= entries_q[k + 1];
				end
			end
		end
		if (cmd.exec) begin
			success_q       <= cmd.success;
			table_full_q    <= cmd.full;
			position_q      <= pos_next;
			element_count_q <= next_count;
		end
	end

	assign success       = success_q;
	assign position      = position_q;
	assign element_count = element_count_q;
	assign table_full    = table_full_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored count exceeds capacity");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (count_q < CNT_W'(CAPACITY)) && !hit)
		else $error("append into a full table or of a present value");
	a_delete_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.delete |-> hit && (count_q != '0))
		else $error("delete without a matching entry");
`endif

endmodule
`default_nettype wire

>>> src/bist_ctrl.sv
// Controller: request sequencing and outcome decode for each transaction.
`default_nettype none
module bist_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	input  wire bist_pkg::status_t  status,
	output bist_pkg::cmd_t          cmd
);
	import bist_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Outcome decode; a duplicate insert is checked before the full test.
	always_comb begin
		cmd         = '0;
		cmd.pos_sel = POS_ZERO;
		cmd.load    = (state_q == ST_IDLE) && start;
		if (state_q == ST_EXEC) begin
			cmd.exec = 1'b1;
			case (status.op)
				OP_INSERT: begin
					if (status.hit) begin
						cmd.pos_sel = POS_HIT;
					end else if (status.full) begin
						cmd.full = 1'b1;
					end else begin
						cmd.append  = 1'b1;
						cmd.success = 1'b1;
						cmd.pos_sel = POS_TAIL;
					end
				end
				OP_LOOKUP: begin
					if (status.hit) begin
						cmd.success = 1'b1;
						cmd.pos_sel = POS_HIT;
					end
				end
				OP_REMOVE: begin
					if (status.hit) begin
						cmd.delete  = 1'b1;
						cmd.success = 1'b1;
						cmd.pos_sel = POS_HIT;
					end
				end
				default: begin
					cmd.pos_sel = POS_ZERO;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy_q |=> busy_q)
		else $error("accepted transaction did not raise busy");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> done_q && !busy_q)
		else $error("transaction did not finish in one execute cycle");
	a_single_action: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.append && cmd.delete) && !(cmd.full && cmd.success))
		else $error("conflicting actions decoded");
`endif

endmodule
`default_nettype wire

>>> dv/bounded_integer_set_table_top_tb.sv
// Self-checking testbench for the bounded integer set table: directed rows, then random requests.
module bounded_integer_set_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bist_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         POOL_SIZE    = 20;
	localparam int         PHASE_ITEMS  = 400;
	localparam int         NUM_PHASES   = 4;
	localparam int         DRAIN_CYCLES = 4;

	typedef struct packed {
		logic             success;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] element_count;
		logic             table_full;
	} set_result_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [VAL_W-1:0] val;
		logic             typed;
		set_result_t      exp;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [1:0]       operation = OP_INSERT;
	logic [VAL_W-1:0] value = '0;
	logic             busy;
	logic             done;
	logic             success;
	logic [POS_W-1:0] position;
	logic [CNT_W-1:0] element_count;
	logic             table_full;

	// Shadow copy of the set, kept in step with every accepted transaction.
	logic [VAL_W-1:0] shadow_entries [CAPACITY];
	int               shadow_count = 0;

	set_result_t      pending_results [$];
	logic [VAL_W-1:0] value_pool [POOL_SIZE];
	int               error_count = 0;
	int               request_count = 0;
	int               result_count = 0;
	int               hit_count = 0;
	int               full_refusals = 0;
	int               dup_refusals = 0;

	// Rows with typed expectations are the ones whose result is obvious at a glance.
	stim_row_t directed_rows [25] = '{
		'{OP_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0}},
		'{OP_REMOVE, 32'h0000_0005, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0}},
		'{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0}},
		'{OP_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 4'd0, 5'd1, 1'b0}},
		'{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd1, 5'd2, 1'b0}},
		'{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 4'd2, 5'd3, 1'b0}},
		'{OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd3, 5'd4, 1'b0}},
		'{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, 4'd1, 5'd4, 1'b0}},
		'{OP_LOOKUP, 32'h8000_0000, 1'b1, '{1'b1, 4'd0, 5'd4, 1'b0}},
		'{OP_REMOVE, 32'h8000_0000, 1'b1, '{1'b1, 4'd0, 5'd3, 1'b0}},
		'{OP_INSERT, 32'h0000_0001, 1'b0, '0},
		'{OP_INSERT, 32'hFFFF_FFFE, 1'b0, '0},
		'{OP_INSERT, 32'h5555_5555, 1'b0, '0},
		'{OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
		'{OP_INSERT, 32'h0000_FFFF, 1'b0, '0},
		'{OP_INSERT, 32'hFFFF_0000, 1'b0, '0},
		'{OP_INSERT, 32'h1234_5678, 1'b0, '0},
		'{OP_INSERT, 32'hEDCB_A987, 1'b0, '0},
		'{OP_INSERT, 32'h0000_0100, 1'b0, '0},
		'{OP_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
		'{OP_INSERT, 32'h8000_0001, 1'b0, '0},
		'{OP_INSERT, 32'h0F0F_0F0F, 1'b0, '0},
		'{OP_INSERT, 32'hF0F0_F0F0, 1'b0, '0},
		'{OP_INSERT, 32'h0000_0002, 1'b1, '{1'b0, 4'd0, 5'd16, 1'b1}},
		'{OP_REMOVE, 32'hF0F0_F0F0, 1'b0, '0}
	};

	bounded_integer_set_table_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.value         (value),
		.done          (done),
		.success       (success),
		.position      (position),
		.element_count (element_count),
		.table_full    (table_full)
	);

	always #5 clk = ~clk;

	// Applies one request to the shadow set and returns what the block must report.
	function automatic set_result_t apply_set_request(logic [1:0] op,
			logic [VAL_W-1:0] val);
		set_result_t r;
		int          hit;
		r   = '0;
		hit = -1;
		for (int k = 0; k < shadow_count; k++) begin
			if (hit < 0 && shadow_entries[k] == val) begin
				hit = k;
			end
		end
		case (op)
			OP_INSERT: begin
				if (hit >= 0) begin
					r.position = hit[POS_W-1:0];
				end else if (shadow_count >= CAPACITY) begin
					r.table_full = 1'b1;
				end else begin
					shadow_entries[shadow_count] = val;
					r.position   = shadow_count[POS_W-1:0];
					r.success    = 1'b1;
					shadow_count++;
				end
			end
			OP_LOOKUP: begin
				if (hit >= 0) begin
					r.success  = 1'b1;
					r.position = hit[POS_W-1:0];
				end
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					for (int k = hit; k + 1 < shadow_count; k++) begin
						shadow_entries[k] = shadow_entries[k + 1];
					end
					shadow_count--;
					r.success  = 1'b1;
					r.position = hit[POS_W-1:0];
				end
			end
			default: begin
			end
		endcase
		r.element_count = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	// Holds start low for a random number of cycles, then presents the request
	// until the block takes it.
	task automatic issue_request(logic [1:0] op, logic [VAL_W-1:0] val, int idle_pct,
			logic typed, set_result_t typed_exp);
		set_result_t pred;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		value     <= val;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pred = apply_set_request(op, val);
		request_count++;
		if (pred.success && op != OP_INSERT) hit_count++;
		if (pred.table_full) full_refusals++;
		if (op == OP_INSERT && !pred.success && !pred.table_full) dup_refusals++;
		pending_results.push_back(typed ? typed_exp : pred);
	endtask

	always @(posedge clk) begin
		set_result_t exp;
		if (done) begin
			result_count++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no transaction outstanding:", $time);
				$display("  success %0b position %0d count %0d full %0b",
					success, position, element_count, table_full);
				error_count++;
			end else begin
				exp = pending_results.pop_front();
				if (success !== exp.success) begin
					$display("%0t: success expected %0b actual %0b",
						$time, exp.success, success);
					error_count++;
				end
				if (position !== exp.position) begin
					$display("%0t: position expected %0d actual %0d",
						$time, exp.position, position);
					error_count++;
				end
				if (element_count !== exp.element_count) begin
					$display("%0t: element_count expected %0d actual %0d",
						$time, exp.element_count, element_count);
					error_count++;
				end
				if (table_full !== exp.table_full) begin
					$display("%0t: table_full expected %0b actual %0b",
						$time, exp.table_full, table_full);
					error_count++;
				end
			end
		end
	end

	initial begin
		int          idle_pcts [NUM_PHASES];
		int          insert_wts [NUM_PHASES];
		int          r;
		logic [1:0]  op;
		logic [VAL_W-1:0] val;
		idle_pcts  = '{0, 75, 33, 0};
		insert_wts = '{45, 40, 30, 50};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			issue_request(directed_rows[i].op, directed_rows[i].val, 0,
				directed_rows[i].typed, directed_rows[i].exp);
		end

		// A small value pool keeps hits, duplicates and a full table common;
		// a share of fully random values keeps misses and all value bits busy.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			value_pool[0] = 32'h8000_0000;
			value_pool[1] = 32'h7FFF_FFFF;
			for (int k = 2; k < POOL_SIZE; k++) begin
				value_pool[k] = $urandom;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < insert_wts[ph]) op = OP_INSERT;
				else if (r < insert_wts[ph] + 25) op = OP_LOOKUP;
				else if (r < 97) op = OP_REMOVE;
				else op = OP_UNUSED;
				if ($urandom_range(99) < 85) val = value_pool[$urandom_range(POOL_SIZE - 1)];
				else val = $urandom;
				issue_request(op, val, idle_pcts[ph], 1'b0, '0);
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d results) over %0d idle phases,",
			request_count, result_count, NUM_PHASES);
		$display("  after a directed table; %0d lookup/remove hits, %0d duplicate inserts, %0d %s",
			hit_count, dup_refusals, full_refusals, "inserts into a full table.");
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("bounded_integer_set_table_top_tb passed");
		end else begin
			$display("bounded_integer_set_table_top_tb failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("bounded_integer_set_table_top_tb failed");
		$finish;
	end

endmodule

>>> sim.f
src/bist_pkg.sv
src/bist_dp.sv
src/bist_ctrl.sv
src/bounded_integer_set_table_top.sv
dv/bounded_integer_set_table_top_tb.sv
